// File: rtl/core/etdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etdq_pkg
// Shared types and constants of the event task dispatch queue.
// ----------------------------------------------------------------------------
package etdq_pkg;

    localparam int TASK_SLOTS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int EVENT_W  = 8;
    localparam int SLOT_W   = 4;
    localparam int NUM_W    = 7;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [NUM_W-1:0] NUM_MAX = 7'd127;

    localparam logic [EVENT_W-1:0] RST_EVENT_INVALID = 8'd0;
    localparam logic [EVENT_W-1:0] RST_EVENT_INIT    = 8'd1;
    localparam logic [NUM_W-1:0]   RST_FIRST_NUMBER  = 7'd0;

    localparam logic [1:0] REG_EVENT_INVALID = 2'd0;
    localparam logic [1:0] REG_EVENT_INIT    = 2'd1;
    localparam logic [1:0] REG_FIRST_NUMBER  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_ARG  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_SLOT  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_LIVE = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_OUTSIDE  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd6;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER,
        OP_UNREGISTER,
        OP_POST,
        OP_POLL
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UNREG,
        S_POST_CHK,
        S_CMP_WRAP,
        S_CMP_LO,
        S_CMP_HI,
        S_POLL
    } t_state;

endpackage

// File: rtl/core/etdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etdq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module etdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/event_task_dispatch_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_task_dispatch_queue_unit
// Task slot table with per-task event windows and a FIFO of pending events.
// ----------------------------------------------------------------------------
// A register scans the slots from slot 0 to the first free one, or to the last
// with a no-slot status. Unregister and poll end in S_UNREG and S_POLL; a post
// goes from S_POST_CHK through S_CMP_WRAP, S_CMP_LO and S_CMP_HI of the shared
// window comparator, or ends in S_POST_CHK when slot or event is refused.
// A new item is taken in the cycle its predecessor's result is shown.
// Synchronous reset clears the live bits and queue pointers and resets registers.
module event_task_dispatch_queue_unit
    import etdq_pkg::*;
#(
    parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [SLOT_W-1:0]   i_task_slot,
    input  logic [EVENT_W-1:0]  i_event_code,
    input  logic [EVENT_W-1:0]  i_window_start,
    input  logic [EVENT_W-1:0]  i_window_end,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_out_slot,
    output logic [NUM_W-1:0]    o_out_task_number,
    output logic [EVENT_W-1:0]  o_out_event
);

    localparam int SW    = $clog2(TASK_SLOTS);
    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int WIN_W = 2 * EVENT_W;
    localparam int Q_W   = SLOT_W + EVENT_W;

    t_state                r_state, n_state;
    t_op                   r_op;
    logic [SLOT_W-1:0]     r_task_slot;
    logic [EVENT_W-1:0]    r_event;
    logic [EVENT_W-1:0]    r_wstart;
    logic [EVENT_W-1:0]    r_wend;
    logic [SW-1:0]         r_idx, n_idx;
    logic [TASK_SLOTS-1:0] r_live, n_live;
    logic [NUM_W-1:0]      r_counter, n_counter;
    logic                  r_ovf, n_ovf;
    logic [QW-1:0]         r_head, n_head;
    logic [QW-1:0]         r_tail, n_tail;
    logic [FW-1:0]         r_fill, n_fill;
    logic                  r_wrap, n_wrap;
    logic                  r_ge_lo, n_ge_lo;
    logic                  r_done, n_done;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [SLOT_W-1:0]     r_oslot, n_oslot;
    logic [NUM_W-1:0]      r_onum, n_onum;
    logic [EVENT_W-1:0]    r_oev, n_oev;
    logic [EVENT_W-1:0]    r_cfg_invalid;
    logic [EVENT_W-1:0]    r_cfg_init;
    logic [NUM_W-1:0]      r_cfg_first;

    logic               w_accept;
    logic               w_cfg_we;
    logic [1:0]         w_cfg_idx;
    logic               w_win_we;
    logic               w_win_re;
    logic [WIN_W-1:0]   w_win_rdata;
    logic [EVENT_W-1:0] w_win_start;
    logic [EVENT_W-1:0] w_win_end;
    logic               w_q_we;
    logic               w_q_re;
    logic [Q_W-1:0]     w_q_rdata;
    logic [SW-1:0]      w_slot_idx;
    logic               w_slot_ok;
    logic [EVENT_W-1:0] w_cmp_a;
    logic [EVENT_W-1:0] w_cmp_b;
    logic               w_cmp_lt;
    logic               w_in_win;

    assign busy      = (r_state != S_IDLE);
    assign w_accept  = start && !busy;
    assign w_cfg_we  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[3:2];
    assign pready    = 1'b1;

    assign w_slot_idx  = SW'(r_task_slot);
    assign w_slot_ok   = (32'(r_task_slot) < 32'(TASK_SLOTS));
    assign w_win_start = w_win_rdata[WIN_W-1:EVENT_W];
    assign w_win_end   = w_win_rdata[EVENT_W-1:0];
    assign w_win_re    = w_accept && (t_op'(i_op) == OP_POST);
    assign w_q_re      = w_accept && (t_op'(i_op) == OP_POLL);

    etdq_ram #(
        .WIDTH (WIN_W),
        .DEPTH (TASK_SLOTS)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (w_win_we),
        .i_waddr (r_idx),
        .i_wdata ({r_wstart, r_wend}),
        .i_re    (w_win_re),
        .i_raddr (SW'(i_task_slot)),
        .o_rdata (w_win_rdata)
    );

    etdq_ram #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (r_tail),
        .i_wdata ({r_task_slot, r_event}),
        .i_re    (w_q_re),
        .i_raddr (r_head),
        .o_rdata (w_q_rdata)
    );

    always_comb begin
        unique case (r_state)
            S_CMP_WRAP: begin
                w_cmp_a = w_win_end;
                w_cmp_b = w_win_start;
            end
            S_CMP_LO: begin
                w_cmp_a = r_event;
                w_cmp_b = w_win_start;
            end
            default: begin
                w_cmp_a = r_event;
                w_cmp_b = w_win_end;
            end
        endcase
    end

    assign w_cmp_lt = (w_cmp_a < w_cmp_b);
    assign w_in_win = r_wrap ? (r_ge_lo || w_cmp_lt) : (r_ge_lo && w_cmp_lt);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_live    = r_live;
        n_counter = r_counter;
        n_ovf     = r_ovf;
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_wrap    = r_wrap;
        n_ge_lo   = r_ge_lo;
        n_done    = 1'b0;
        n_status  = STAT_OK;
        n_oslot   = '0;
        n_onum    = '0;
        n_oev     = '0;
        w_win_we  = 1'b0;
        w_q_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx = '0;
                    unique case (t_op'(i_op))
                        OP_REGISTER:   n_state = S_SCAN;
                        OP_UNREGISTER: n_state = S_UNREG;
                        OP_POST:       n_state = S_POST_CHK;
                        OP_POLL:       n_state = S_POLL;
                    endcase
                end
            end
            S_SCAN: begin
                if (!r_live[r_idx]) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (r_ovf || (r_counter == NUM_MAX)) begin
                        n_ovf    = 1'b1;
                        n_status = STAT_BAD_ARG;
                    end else begin
                        n_counter     = r_counter + 1'b1;
                        n_live[r_idx] = 1'b1;
                        w_win_we      = 1'b1;
                        n_oslot       = SLOT_W'(r_idx);
                        n_onum        = r_counter + 1'b1;
                    end
                end else if (r_idx == SW'(TASK_SLOTS - 1)) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = STAT_NO_SLOT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_UNREG: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (w_slot_ok) begin
                    n_live[w_slot_idx] = 1'b0;
                end else begin
                    n_status = STAT_BAD_ARG;
                end
            end
            S_POST_CHK: begin
                if (!(w_slot_ok && r_live[w_slot_idx])) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = STAT_NOT_LIVE;
                end else if ((r_event == r_cfg_invalid) || (r_event == r_cfg_init)) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = STAT_BAD_ARG;
                end else begin
                    n_state = S_CMP_WRAP;
                end
            end
            S_CMP_WRAP: begin
                n_wrap  = w_cmp_lt;
                n_state = S_CMP_LO;
            end
            S_CMP_LO: begin
                n_ge_lo = !w_cmp_lt;
                n_state = S_CMP_HI;
            end
            S_CMP_HI: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (!w_in_win) begin
                    n_status = STAT_OUTSIDE;
                end else if (r_fill == FW'(QUEUE_DEPTH)) begin
                    n_status = STAT_FULL;
                end else begin
                    w_q_we = 1'b1;
                    n_tail = (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    n_fill = r_fill + 1'b1;
                end
            end
            S_POLL: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (r_fill == '0) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_oslot = w_q_rdata[Q_W-1:EVENT_W];
                    n_oev   = w_q_rdata[EVENT_W-1:0];
                    n_head  = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_fill  = r_fill - 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_live        <= '0;
            r_counter     <= RST_FIRST_NUMBER;
            r_ovf         <= 1'b0;
            r_head        <= '0;
            r_tail        <= '0;
            r_fill        <= '0;
            r_done        <= 1'b0;
            r_cfg_invalid <= RST_EVENT_INVALID;
            r_cfg_init    <= RST_EVENT_INIT;
            r_cfg_first   <= RST_FIRST_NUMBER;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_live  <= n_live;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_done  <= n_done;
            if (w_cfg_we && (w_cfg_idx == REG_EVENT_INVALID)) begin
                r_cfg_invalid <= pwdata[EVENT_W-1:0];
            end
            if (w_cfg_we && (w_cfg_idx == REG_EVENT_INIT)) begin
                r_cfg_init <= pwdata[EVENT_W-1:0];
            end
            if (w_cfg_we && (w_cfg_idx == REG_FIRST_NUMBER)) begin
                r_cfg_first <= pwdata[NUM_W-1:0];
                r_counter   <= pwdata[NUM_W-1:0];
                r_ovf       <= 1'b0;
            end else begin
                r_counter <= n_counter;
                r_ovf     <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= t_op'(i_op);
            r_task_slot <= i_task_slot;
            r_event     <= i_event_code;
            r_wstart    <= i_window_start;
            r_wend      <= i_window_end;
        end
        r_wrap   <= n_wrap;
        r_ge_lo  <= n_ge_lo;
        r_status <= n_status;
        r_oslot  <= n_oslot;
        r_onum   <= n_onum;
        r_oev    <= n_oev;
    end

    always_comb begin
        prdata = '0;
        case (w_cfg_idx)
            REG_EVENT_INVALID: prdata = DATA_W'(r_cfg_invalid);
            REG_EVENT_INIT:    prdata = DATA_W'(r_cfg_init);
            REG_FIRST_NUMBER:  prdata = DATA_W'(r_cfg_first);
            default:           prdata = '0;
        endcase
    end

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_out_slot        = (r_op == OP_UNREGISTER) ? '0 : r_oslot;
    assign o_out_task_number = r_onum;
    assign o_out_event       = r_oev;

endmodule

// File: rtl/core/etdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etdq_checker
// Port-level checks of the event task dispatch queue, bound to the top level.
// ----------------------------------------------------------------------------
module etdq_checker
    import etdq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input logic [STATUS_W-1:0] o_status,
    input logic [SLOT_W-1:0]   o_out_slot,
    input logic [NUM_W-1:0]    o_out_task_number,
    input logic [EVENT_W-1:0]  o_out_event
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted item did not make the block busy.");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("Result strobe without a preceding busy cycle.");

    a_busy_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("Item finished without a result strobe.");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= STAT_EMPTY))
        else $error("Result status code out of range.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != STAT_OK)) |->
        ((o_out_slot == '0) && (o_out_task_number == '0) && (o_out_event == '0)))
        else $error("Refused item carries nonzero result fields.");

endmodule

bind event_task_dispatch_queue_unit etdq_checker u_etdq_checker (.*);

// File: sim/tb_event_task_dispatch_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_task_dispatch_queue_unit
// Self-checking bench for the event task dispatch queue. Commands go in over
// the start/busy handshake, and the registers are set over the APB port. A
// behavioral model of the slot table, the identifier counter and the event
// FIFO predicts each result, and every strobed result is compared with it.
// The run has directed cases first and then random traffic in phases, each
// phase with its own register settings and operation mix.
// ----------------------------------------------------------------------------
module tb_event_task_dispatch_queue_unit;
    import etdq_pkg::*;

    localparam int SLOT_COUNT  = TASK_SLOTS_DEF;
    localparam int QUEUE_SLOTS = QUEUE_DEPTH_DEF;

    typedef struct packed {
        t_op                op;
        logic [SLOT_W-1:0]  slot;
        logic [EVENT_W-1:0] ev;
        logic [EVENT_W-1:0] ws;
        logic [EVENT_W-1:0] we;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [NUM_W-1:0]    num;
        logic [EVENT_W-1:0]  ev;
    } t_result;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [EVENT_W-1:0] ev;
    } t_queued;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     i_op;
    logic [SLOT_W-1:0]   i_task_slot;
    logic [EVENT_W-1:0]  i_event_code;
    logic [EVENT_W-1:0]  i_window_start;
    logic [EVENT_W-1:0]  i_window_end;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_out_slot;
    logic [NUM_W-1:0]    o_out_task_number;
    logic [EVENT_W-1:0]  o_out_event;

    logic [EVENT_W-1:0] cfg_invalid;
    logic [EVENT_W-1:0] cfg_init;
    logic [NUM_W-1:0]   cfg_first;
    bit                 slot_live [SLOT_COUNT];
    logic [EVENT_W-1:0] win_lo [SLOT_COUNT];
    logic [EVENT_W-1:0] win_hi [SLOT_COUNT];
    logic [NUM_W-1:0]   id_counter;
    bit                 id_exhausted;
    t_queued            queued_events [$];
    t_result            outcomes_due [$];
    int                 error_count;
    bit                 no_idle;

    event_task_dispatch_queue_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_task_slot       (i_task_slot),
        .i_event_code      (i_event_code),
        .i_window_start    (i_window_start),
        .i_window_end      (i_window_end),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_out_slot        (o_out_slot),
        .o_out_task_number (o_out_task_number),
        .o_out_event       (o_out_event)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        if (error_count < 10) begin
            $display("%s", what);
        end
        error_count++;
    endtask

    function automatic bit event_in_window(input logic [7:0] lo, input logic [7:0] hi,
                                           input logic [7:0] ev);
        if (lo > hi) begin
            return (ev >= lo) || (ev < hi);
        end
        return (ev >= lo) && (ev < hi);
    endfunction

    function automatic t_result dispatch_outcome(input t_cmd c);
        t_result r;
        t_queued q;
        int      free_idx;
        r = '0;
        r.status = STAT_OK;
        free_idx = -1;
        case (c.op)
            OP_REGISTER: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!slot_live[i] && free_idx < 0) begin
                        free_idx = i;
                    end
                end
                if (free_idx < 0) begin
                    r.status = STAT_NO_SLOT;
                end else if (id_exhausted || id_counter == NUM_MAX) begin
                    id_exhausted = 1'b1;
                    r.status = STAT_BAD_ARG;
                end else begin
                    id_counter = id_counter + 1'b1;
                    slot_live[free_idx] = 1'b1;
                    win_lo[free_idx] = c.ws;
                    win_hi[free_idx] = c.we;
                    r.slot = free_idx[SLOT_W-1:0];
                    r.num = id_counter;
                end
            end
            OP_UNREGISTER: begin
                slot_live[c.slot] = 1'b0;
                win_lo[c.slot] = '0;
                win_hi[c.slot] = '0;
            end
            OP_POST: begin
                if (!slot_live[c.slot]) begin
                    r.status = STAT_NOT_LIVE;
                end else if (c.ev == cfg_invalid || c.ev == cfg_init) begin
                    r.status = STAT_BAD_ARG;
                end else if (!event_in_window(win_lo[c.slot], win_hi[c.slot], c.ev)) begin
                    r.status = STAT_OUTSIDE;
                end else if (queued_events.size() >= QUEUE_SLOTS) begin
                    r.status = STAT_FULL;
                end else begin
                    q.slot = c.slot;
                    q.ev = c.ev;
                    queued_events.push_back(q);
                end
            end
            default: begin
                if (queued_events.size() == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    q = queued_events.pop_front();
                    r.slot = q.slot;
                    r.ev = q.ev;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (outcomes_due.size() == 0) begin
                flag_mismatch($sformatf("Result with nothing expected: status %0d slot %0d",
                                        o_status, o_out_slot));
            end else begin
                want = outcomes_due.pop_front();
                if (o_status !== want.status || o_out_slot !== want.slot ||
                    o_out_task_number !== want.num || o_out_event !== want.ev) begin
                    flag_mismatch($sformatf(
                        "Mismatch: expected st %0d slot %0d num %0d ev %0d, got %0d %0d %0d %0d",
                        want.status, want.slot, want.num, want.ev,
                        o_status, o_out_slot, o_out_task_number, o_out_event));
                end
            end
        end
    end

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        for (int k = 0; k < 4000 && outcomes_due.size() != 0; k++) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic issue_command(input t_op op, input logic [3:0] slot, input logic [7:0] ev,
                                 input logic [7:0] ws, input logic [7:0] we);
        t_cmd c;
        int   gap;
        c.op = op;
        c.slot = slot;
        c.ev = ev;
        c.ws = ws;
        c.we = we;
        @(negedge i_clk);
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_op <= op;
        i_task_slot <= slot;
        i_event_code <= ev;
        i_window_start <= ws;
        i_window_end <= we;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        outcomes_due.push_back(dispatch_outcome(c));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        logic [DATA_W-1:0] stored;
        drain_results();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_EVENT_INVALID: begin
                cfg_invalid = value[EVENT_W-1:0];
                stored = {{(DATA_W-EVENT_W){1'b0}}, value[EVENT_W-1:0]};
            end
            REG_EVENT_INIT: begin
                cfg_init = value[EVENT_W-1:0];
                stored = {{(DATA_W-EVENT_W){1'b0}}, value[EVENT_W-1:0]};
            end
            default: begin
                cfg_first = value[NUM_W-1:0];
                id_counter = value[NUM_W-1:0];
                id_exhausted = 1'b0;
                stored = {{(DATA_W-NUM_W){1'b0}}, value[NUM_W-1:0]};
            end
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== stored) begin
            flag_mismatch($sformatf("Register %0d read back %0h, expected %0h",
                                    idx, readback, stored));
        end
    endtask

    task automatic test_idle_table();
        issue_command(OP_POLL, 4'd0, 8'd0, 8'd0, 8'd0);
        issue_command(OP_POST, 4'd15, 8'd200, 8'd0, 8'd0);
        issue_command(OP_UNREGISTER, 4'd15, 8'd0, 8'd0, 8'd0);
        drain_results();
    endtask

    task automatic test_window_checks();
        issue_command(OP_REGISTER, 4'd0, 8'd0, 8'd10, 8'd20);
        issue_command(OP_REGISTER, 4'd0, 8'd0, 8'd250, 8'd5);
        issue_command(OP_REGISTER, 4'd0, 8'd0, 8'd7, 8'd7);
        issue_command(OP_REGISTER, 4'd0, 8'd0, 8'd255, 8'd0);
        issue_command(OP_POST, 4'd0, 8'd10, 8'd0, 8'd0);
        issue_command(OP_POST, 4'd0, 8'd20, 8'd0, 8'd0);
        issue_command(OP_POST, 4'd0, 8'd9, 8'd0, 8'd0);
        issue_command(OP_POST, 4'd1, 8'd255, 8'd0, 8'd0);
        issue_command(OP_POST, 4'd1, 8'd4, 8'd0, 8'd0);
        issue_command(OP_POST, 4'd1, 8'd5, 8'd0, 8'd0);
        issue_command(OP_POST, 4'd1, 8'd0, 8'd0, 8'd0);
        issue_command(OP_POST, 4'd2, 8'd7, 8'd0, 8'd0);
        issue_command(OP_POST, 4'd3, 8'd255, 8'd0, 8'd0);
        issue_command(OP_POST, 4'd3, 8'd254, 8'd0, 8'd0);
        issue_command(OP_POST, 4'd0, 8'd1, 8'd0, 8'd0);
        issue_command(OP_UNREGISTER, 4'd0, 8'd0, 8'd0, 8'd0);
        repeat (5) issue_command(OP_POLL, 4'd0, 8'd0, 8'd0, 8'd0);
        drain_results();
    endtask

    task automatic test_counter_limit();
        write_reg(REG_FIRST_NUMBER, 32'd126);
        issue_command(OP_REGISTER, 4'd0, 8'd0, 8'd0, 8'd255);
        issue_command(OP_REGISTER, 4'd0, 8'd0, 8'd0, 8'd255);
        issue_command(OP_UNREGISTER, 4'd4, 8'd0, 8'd0, 8'd0);
        issue_command(OP_REGISTER, 4'd0, 8'd0, 8'd0, 8'd255);
        write_reg(REG_FIRST_NUMBER, 32'd127);
        issue_command(OP_REGISTER, 4'd0, 8'd0, 8'd0, 8'd255);
        write_reg(REG_FIRST_NUMBER, 32'd0);
        issue_command(OP_REGISTER, 4'd0, 8'd0, 8'd3, 8'd200);
        drain_results();
    endtask

    task automatic run_random_phase(input int n_items, input int w_reg, input int w_unreg,
                                    input int w_post, input int w_poll,
                                    input logic [7:0] inv, input logic [7:0] init,
                                    input logic [6:0] first);
        t_op  op;
        logic [3:0] slot;
        logic [7:0] ev;
        logic [7:0] span8;
        int   pick;
        int   roll;
        int   span;
        int   live_idx [$];
        write_reg(REG_EVENT_INVALID, {24'd0, inv});
        write_reg(REG_EVENT_INIT, {24'd0, init});
        write_reg(REG_FIRST_NUMBER, {25'd0, first});
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, w_reg + w_unreg + w_post + w_poll - 1);
            if (pick < w_reg) begin
                op = OP_REGISTER;
            end else if (pick < w_reg + w_unreg) begin
                op = OP_UNREGISTER;
            end else if (pick < w_reg + w_unreg + w_post) begin
                op = OP_POST;
            end else begin
                op = OP_POLL;
            end
            slot = 4'($urandom);
            ev = 8'($urandom);
            live_idx.delete();
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (slot_live[i]) begin
                    live_idx.push_back(i);
                end
            end
            roll = $urandom_range(0, 9);
            if (live_idx.size() != 0 && ((op == OP_UNREGISTER && roll < 7) ||
                                         (op == OP_POST && roll < 8))) begin
                slot = 4'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
            end
            if (op == OP_POST) begin
                roll = $urandom_range(0, 9);
                span8 = win_hi[slot] - win_lo[slot];
                span = int'(span8);
                if (roll == 0) begin
                    ev = $urandom_range(0, 1) ? cfg_invalid : cfg_init;
                end else if (roll < 7 && slot_live[slot] && span != 0) begin
                    ev = win_lo[slot] + 8'($urandom_range(0, span - 1));
                end
            end
            issue_command(op, slot, ev, 8'($urandom), 8'($urandom));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(300, 2, 1, 4, 3, 8'd0, 8'd1, 7'd0);
        run_random_phase(300, 5, 1, 2, 2, 8'd255, 8'd0, 7'd100);
        run_random_phase(300, 1, 1, 6, 1, 8'd255, 8'd255, 7'd0);
        run_random_phase(300, 3, 3, 3, 3, 8'($urandom), 8'($urandom), 7'd127);
        run_random_phase(300, 2, 1, 3, 5, 8'($urandom), 8'($urandom), 7'($urandom));
        run_random_phase(300, 2, 1, 4, 3, 8'($urandom), 8'($urandom),
                         7'($urandom_range(0, 60)));
    endtask

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        i_op = '0;
        i_task_slot = '0;
        i_event_code = '0;
        i_window_start = '0;
        i_window_end = '0;
        error_count = 0;
        no_idle = 1'b0;
        cfg_invalid = RST_EVENT_INVALID;
        cfg_init = RST_EVENT_INIT;
        cfg_first = RST_FIRST_NUMBER;
        id_counter = RST_FIRST_NUMBER;
        id_exhausted = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_live[i] = 1'b0;
            win_lo[i] = '0;
            win_hi[i] = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_table();
        test_window_checks();
        test_counter_limit();
        test_random_traffic();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (outcomes_due.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/etdq_pkg.sv
rtl/core/etdq_ram.sv
rtl/core/event_task_dispatch_queue_unit.sv
rtl/core/etdq_checker.sv
sim/tb_event_task_dispatch_queue_unit.sv
